>>> rtl/swrae_pkg.sv
// shared constants, types and checksum helpers of the stop-and-wait receiver ack engine
`timescale 1ns / 1ps
package swrae_pkg;

  localparam int unsigned PAYLOAD_BYTES = 1024;
  localparam int unsigned FRAME_WORDS   = 520;
  localparam int unsigned BODY_START    = 7;

  localparam int unsigned IDX_W = $clog2(FRAME_WORDS + 1);
  localparam int unsigned LEN_W = $clog2(PAYLOAD_BYTES + 1);

  // word positions inside a frame
  localparam logic [IDX_W-1:0] W_SEQ_LO = IDX_W'(0);
  localparam logic [IDX_W-1:0] W_SEQ_HI = IDX_W'(1);
  localparam logic [IDX_W-1:0] W_FLAGS  = IDX_W'(4);
  localparam logic [IDX_W-1:0] W_LEN    = IDX_W'(5);
  localparam logic [IDX_W-1:0] W_CKSUM  = IDX_W'(6);

  // frame flag bits
  localparam logic [5:0] F_SYN      = 6'd1;
  localparam logic [5:0] F_ACK      = 6'd2;
  localparam logic [5:0] F_FIN      = 6'd4;
  localparam logic [5:0] F_DATA     = 6'd8;
  localparam logic [5:0] F_FILENAME = 6'd16;
  localparam logic [5:0] F_CLOSE    = 6'd32;

  // result event codes
  localparam logic [1:0] EV_REPLY  = 2'd0;
  localparam logic [1:0] EV_BAD    = 2'd1;
  localparam logic [1:0] EV_NONE   = 2'd2;
  localparam logic [1:0] EV_CLOSED = 2'd3;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // one received frame, as classified by the front end
  typedef struct packed {
    logic [31:0]      sum;    // ones-complement sum without the checksum word
    logic [15:0]      cksum;
    logic [31:0]      seq;
    logic [31:0]      next;   // seq + 1
    logic [5:0]       flags;
    logic [LEN_W-1:0] len;    // saturated length
    logic [31:0]      echo;   // length word plus body words
  } desc_t;

  typedef struct packed {
    logic [1:0]       event_res;
    logic [31:0]      ack;
    logic [5:0]       flags;
    logic [15:0]      cksum;
    logic             echo;
    logic             deliver;
    logic             is_name;
    logic [LEN_W-1:0] len;
    logic             last;
  } res_t;

  // two end-around folds cover any 32-bit sum
  function automatic logic [15:0] fold_cpl(input logic [31:0] s);
    logic [16:0] s1;
    logic [16:0] s2;
    s1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    s2 = {1'b0, s1[15:0]} + {16'b0, s1[16]};
    return ~s2[15:0];
  endfunction

  function automatic logic [15:0] ack_cksum(input logic [31:0] ack);
    return fold_cpl({16'b0, ack[15:0]} + {16'b0, ack[31:16]} + {26'b0, F_ACK});
  endfunction

endpackage

>>> rtl/swrae_front.sv
// front end: takes frame words, folds the running sums and captures the header
`timescale 1ns / 1ps
module swrae_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [15:0]          word_i,
  input  logic                 frame_end_i,
  input  logic                 full_i,
  output logic                 push_o,
  output swrae_pkg::desc_t     desc_o
);
  import swrae_pkg::*;

  logic [IDX_W-1:0] idx_q, idx_d;
  logic [31:0]      sum_q, sum_d;
  logic [31:0]      echo_q, echo_d;
  logic [31:0]      seq_q, seq_d;
  logic [5:0]       flags_q, flags_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [15:0]      ck_q, ck_d;

  logic             take;
  logic             counted;
  logic [31:0]      sum_m, echo_m, seq_m;
  logic [5:0]       flags_m;
  logic [LEN_W-1:0] len_m;
  logic [15:0]      ck_m;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && in_ready_o;
  assign counted    = idx_q < IDX_W'(FRAME_WORDS);

  // header and sums with the current word merged in
  always_comb begin
    seq_m   = seq_q;
    flags_m = flags_q;
    len_m   = len_q;
    ck_m    = ck_q;
    sum_m   = sum_q;
    echo_m  = echo_q;
    if (counted) begin
      if (idx_q == W_SEQ_LO) seq_m = {seq_q[31:16], word_i};
      if (idx_q == W_SEQ_HI) seq_m = {word_i, seq_q[15:0]};
      if (idx_q == W_FLAGS) flags_m = word_i[5:0];
      if (idx_q == W_LEN) begin
        if (word_i > 16'(PAYLOAD_BYTES)) len_m = LEN_W'(PAYLOAD_BYTES);
        else len_m = word_i[LEN_W-1:0];
      end
      if (idx_q == W_CKSUM) ck_m = word_i;
      else sum_m = sum_q + {16'b0, word_i};
      if (idx_q == W_LEN || idx_q >= IDX_W'(BODY_START)) echo_m = echo_q + {16'b0, word_i};
    end
  end

  always_comb begin
    idx_d   = idx_q;
    sum_d   = sum_q;
    echo_d  = echo_q;
    seq_d   = seq_q;
    flags_d = flags_q;
    len_d   = len_q;
    ck_d    = ck_q;
    if (take) begin
      if (frame_end_i) begin
        idx_d   = '0;
        sum_d   = '0;
        echo_d  = '0;
        seq_d   = '0;
        flags_d = '0;
        len_d   = '0;
        ck_d    = '0;
      end else begin
        if (counted) idx_d = idx_q + 1'b1;
        sum_d   = sum_m;
        echo_d  = echo_m;
        seq_d   = seq_m;
        flags_d = flags_m;
        len_d   = len_m;
        ck_d    = ck_m;
      end
    end
  end

  assign push_o       = take && frame_end_i;
  assign desc_o.sum   = sum_m;
  assign desc_o.cksum = ck_m;
  assign desc_o.seq   = seq_m;
  assign desc_o.next  = seq_m + 32'd1;
  assign desc_o.flags = flags_m;
  assign desc_o.len   = len_m;
  assign desc_o.echo  = echo_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      sum_q   <= '0;
      echo_q  <= '0;
      seq_q   <= '0;
      flags_q <= '0;
      len_q   <= '0;
      ck_q    <= '0;
    end else begin
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      echo_q  <= echo_d;
      seq_q   <= seq_d;
      flags_q <= flags_d;
      len_q   <= len_d;
      ck_q    <= ck_d;
    end
  end

endmodule

>>> rtl/swrae_queue.sv
// short frame descriptor queue between front end and back end
`timescale 1ns / 1ps
module swrae_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  swrae_pkg::desc_t desc_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output swrae_pkg::desc_t desc_o
);
  import swrae_pkg::*;

  desc_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign desc_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    if (do_pop) rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> rtl/swrae_back.sv
// back end: connection state, reply headers and the output register
`timescale 1ns / 1ps
module swrae_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  swrae_pkg::desc_t desc_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output swrae_pkg::res_t  res_o
);
  import swrae_pkg::*;

  logic        out_valid_q, out_valid_d;
  res_t        res_q, res_d;
  logic        fin_pend_q, fin_pend_d;
  logic [31:0] exp_q, exp_d;
  logic        open_q, open_d;
  logic        cwait_q, cwait_d;
  logic        closed_q, closed_d;

  logic        can_load;
  logic        good;
  logic        in_order;
  logic [15:0] syn_ck;
  res_t        frame_res;

  assign can_load = !out_valid_q || out_ready_i;
  assign pop_o    = can_load && !fin_pend_q && q_valid_i;
  assign good     = fold_cpl(desc_i.sum) == desc_i.cksum;
  assign in_order = desc_i.seq == exp_q;
  assign syn_ck   = fold_cpl({16'b0, desc_i.next[15:0]} + {16'b0, desc_i.next[31:16]}
                             + {26'b0, F_SYN | F_ACK} + desc_i.echo);

  // handling of the frame at the head of the queue
  always_comb begin
    frame_res           = '0;
    frame_res.event_res = EV_NONE;
    frame_res.last      = 1'b1;
    exp_d               = exp_q;
    open_d              = open_q;
    cwait_d             = cwait_q;
    closed_d            = closed_q;
    fin_pend_d          = fin_pend_q;
    if (closed_q) begin
      frame_res.event_res = EV_CLOSED;
    end else if (!good) begin
      cwait_d             = 1'b0;
      frame_res.event_res = EV_BAD;
    end else if (cwait_q) begin
      cwait_d = 1'b0;
      if ((desc_i.flags & F_ACK) != '0) begin
        closed_d            = 1'b1;
        frame_res.event_res = EV_CLOSED;
      end
    end else if ((desc_i.flags & F_SYN) != '0) begin
      frame_res.event_res = EV_REPLY;
      frame_res.ack       = desc_i.next;
      frame_res.flags     = F_SYN | F_ACK;
      frame_res.cksum     = syn_ck;
      frame_res.echo      = 1'b1;
    end else if ((desc_i.flags & (F_FILENAME | F_DATA)) != '0) begin
      if (!in_order) begin
        frame_res.event_res = EV_REPLY;
        frame_res.ack       = exp_q;
        frame_res.flags     = F_ACK;
        frame_res.cksum     = ack_cksum(exp_q);
      end else if ((desc_i.flags & F_FILENAME) != '0 || open_q) begin
        // a new file name replaces any open file
        open_d              = 1'b1;
        exp_d               = desc_i.next;
        frame_res.event_res = EV_REPLY;
        frame_res.ack       = desc_i.next;
        frame_res.flags     = F_ACK;
        frame_res.cksum     = ack_cksum(desc_i.next);
        frame_res.deliver   = 1'b1;
        frame_res.is_name   = (desc_i.flags & F_FILENAME) != '0;
        frame_res.len       = desc_i.len;
      end
    end else if ((desc_i.flags & (F_FIN | F_CLOSE)) != '0) begin
      frame_res.event_res = EV_REPLY;
      frame_res.ack       = desc_i.next;
      frame_res.flags     = F_ACK;
      frame_res.cksum     = ack_cksum(desc_i.next);
      if ((desc_i.flags & F_FIN) != '0) begin
        open_d = 1'b0;
        exp_d  = '0;
      end else begin
        // ack now, our own fin follows as the second result
        frame_res.last = 1'b0;
        fin_pend_d     = 1'b1;
        cwait_d        = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    res_d       = res_q;
    if (can_load) begin
      out_valid_d = fin_pend_q || q_valid_i;
      if (fin_pend_q) begin
        res_d           = '0;
        res_d.event_res = EV_REPLY;
        res_d.flags     = F_FIN;
        res_d.cksum     = fold_cpl({26'b0, F_FIN});
        res_d.last      = 1'b1;
      end else if (q_valid_i) begin
        res_d = frame_res;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fin_pend_q  <= 1'b0;
      exp_q       <= '0;
      open_q      <= 1'b0;
      cwait_q     <= 1'b0;
      closed_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (can_load && fin_pend_q) begin
        fin_pend_q <= 1'b0;
      end else if (pop_o) begin
        fin_pend_q <= fin_pend_d;
        exp_q      <= exp_d;
        open_q     <= open_d;
        cwait_q    <= cwait_d;
        closed_q   <= closed_d;
      end
    end
  end

endmodule

>>> rtl/stop_wait_receiver_ack_engine.sv
// top level of the stop-and-wait receiver ack engine
`timescale 1ns / 1ps
// Frame words are taken one per cycle while the descriptor queue is not full,
// including across frame boundaries; only the final word of a frame pushes
// into the two-entry descriptor queue, but input ready drops for every word
// while that queue is full. Each frame gives one result, or two for a CLOSE
// frame (ack, then fin), and the back end issues one result per cycle from its
// output register while the output side is ready. No clearing pass is needed
// after reset.
module stop_wait_receiver_ack_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [15:0]                 word_i,
  input  logic                        frame_end_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  event_res_o,
  output logic [31:0]                 reply_seq_o,
  output logic [31:0]                 reply_ack_o,
  output logic [5:0]                  reply_flags_o,
  output logic [15:0]                 reply_checksum_o,
  output logic                        echo_payload_o,
  output logic                        deliver_o,
  output logic                        deliver_is_name_o,
  output logic [swrae_pkg::LEN_W-1:0] deliver_length_o,
  output logic                        last_o
);
  import swrae_pkg::*;

  logic  q_full, q_push, q_valid, q_pop;
  desc_t push_desc, head_desc;
  res_t  res;

  swrae_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .word_i      (word_i),
    .frame_end_i (frame_end_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .desc_o      (push_desc)
  );

  swrae_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .desc_o  (head_desc)
  );

  swrae_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .desc_i      (head_desc),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign event_res_o       = res.event_res;
  assign reply_seq_o       = '0;
  assign reply_ack_o       = res.ack;
  assign reply_flags_o     = res.flags;
  assign reply_checksum_o  = res.cksum;
  assign echo_payload_o    = res.echo;
  assign deliver_o         = res.deliver;
  assign deliver_is_name_o = res.is_name;
  assign deliver_length_o  = res.len;
  assign last_o            = res.last;

  // non-reply events carry nothing and always end the frame
  a_event_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_REPLY |-> last_o && !deliver_o && !echo_payload_o)
    else $error("non-reply result carries reply fields");

  // delivered data is always acknowledged with a plain ack
  a_deliver_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && deliver_o |-> event_res_o == EV_REPLY && reply_flags_o == F_ACK)
    else $error("delivery without ack reply");

  // the close ack is followed right away by our fin
  a_close_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && reply_flags_o == F_FIN && last_o)
    else $error("close ack not followed by fin");

endmodule

>>> test/tb_stop_wait_receiver_ack_engine.sv
// testbench of the stop-and-wait receiver ack engine: frame traffic checked against a reply predictor
`timescale 1ns / 1ps
module tb_stop_wait_receiver_ack_engine;
  import swrae_pkg::*;

  typedef struct {
    logic [1:0]       ev;
    logic [31:0]      seq;
    logic [31:0]      ack;
    logic [5:0]       flags;
    logic [15:0]      cksum;
    logic             echo;
    logic             deliver;
    logic             is_name;
    logic [LEN_W-1:0] len;
    logic             last;
  } reply_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [15:0]      word_i      = 16'd0;
  logic             frame_end_i = 1'b0;
  logic             out_ready_i = 1'b0;
  logic             in_ready_o;
  logic             out_valid_o;
  logic [1:0]       event_res_o;
  logic [31:0]      reply_seq_o;
  logic [31:0]      reply_ack_o;
  logic [5:0]       reply_flags_o;
  logic [15:0]      reply_checksum_o;
  logic             echo_payload_o;
  logic             deliver_o;
  logic             deliver_is_name_o;
  logic [LEN_W-1:0] deliver_length_o;
  logic             last_o;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int stall_hold      = 0;
  int words_sent      = 0;
  int mismatch_count  = 0;

  reply_t pending_replies[$];

  // receiver state as predicted
  int          cur_idx;
  logic [31:0] cur_sum;
  logic [31:0] cur_body;
  logic [31:0] cur_seq;
  logic [15:0] cur_flags;
  logic [15:0] cur_len;
  logic [15:0] cur_cksum;
  logic [31:0] exp_seq;
  logic        file_is_open;
  logic        close_pending;
  logic        link_closed;

  stop_wait_receiver_ack_engine DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .word_i            (word_i),
    .frame_end_i       (frame_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_res_o       (event_res_o),
    .reply_seq_o       (reply_seq_o),
    .reply_ack_o       (reply_ack_o),
    .reply_flags_o     (reply_flags_o),
    .reply_checksum_o  (reply_checksum_o),
    .echo_payload_o    (echo_payload_o),
    .deliver_o         (deliver_o),
    .deliver_is_name_o (deliver_is_name_o),
    .deliver_length_o  (deliver_length_o),
    .last_o            (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] ones_fold(input logic [31:0] s);
    logic [31:0] t;
    t = s;
    while (t[31:16] != 16'd0) t = {16'd0, t[15:0]} + {16'd0, t[31:16]};
    return ~t[15:0];
  endfunction

  function automatic logic flag_set(input logic [5:0] f);
    return (cur_flags & {10'd0, f}) != 16'd0;
  endfunction

  function automatic void queue_reply(input logic [1:0] ev, input logic [31:0] ack,
                                      input logic [5:0] flags, input logic [15:0] ck,
                                      input logic echo, input logic del, input logic is_name,
                                      input logic [LEN_W-1:0] len, input logic last);
    reply_t r;
    r.ev      = ev;
    r.seq     = 32'd0;
    r.ack     = ack;
    r.flags   = flags;
    r.cksum   = ck;
    r.echo    = echo;
    r.deliver = del;
    r.is_name = is_name;
    r.len     = len;
    r.last    = last;
    pending_replies.push_back(r);
  endfunction

  function automatic void queue_ack(input logic [31:0] ack, input logic del, input logic is_name,
                                    input logic [LEN_W-1:0] len, input logic last);
    logic [31:0] s;
    s = {16'd0, ack[15:0]} + {16'd0, ack[31:16]} + {26'd0, F_ACK};
    queue_reply(EV_REPLY, ack, F_ACK, ones_fold(s), 1'b0, del, is_name, len, last);
  endfunction

  function automatic void queue_status(input logic [1:0] ev);
    queue_reply(ev, 32'd0, 6'd0, 16'd0, 1'b0, 1'b0, 1'b0, '0, 1'b1);
  endfunction

  function automatic void clear_frame();
    cur_idx   = 0;
    cur_sum   = 32'd0;
    cur_body  = 32'd0;
    cur_seq   = 32'd0;
    cur_flags = 16'd0;
    cur_len   = 16'd0;
    cur_cksum = 16'd0;
  endfunction

  function automatic void predict_frame();
    logic             good;
    logic [31:0]      nxt;
    logic [LEN_W-1:0] dlen;
    logic [31:0]      s;
    good = (ones_fold(cur_sum) == cur_cksum);
    nxt  = cur_seq + 32'd1;
    dlen = (cur_len > PAYLOAD_BYTES) ? LEN_W'(PAYLOAD_BYTES) : LEN_W'(cur_len);
    if (link_closed) begin
      queue_status(EV_CLOSED);
    end else if (!good) begin
      close_pending = 1'b0;
      queue_status(EV_BAD);
    end else if (close_pending) begin
      // the frame after a close is only looked at for its ack bit
      close_pending = 1'b0;
      if (flag_set(F_ACK)) begin
        link_closed = 1'b1;
        queue_status(EV_CLOSED);
      end else begin
        queue_status(EV_NONE);
      end
    end else if (flag_set(F_SYN)) begin
      s = {16'd0, nxt[15:0]} + {16'd0, nxt[31:16]} + {26'd0, F_SYN | F_ACK}
          + {16'd0, cur_len} + cur_body;
      queue_reply(EV_REPLY, nxt, F_SYN | F_ACK, ones_fold(s), 1'b1, 1'b0, 1'b0, '0, 1'b1);
    end else if (flag_set(F_FILENAME)) begin
      if (cur_seq != exp_seq) begin
        queue_ack(exp_seq, 1'b0, 1'b0, '0, 1'b1);
      end else begin
        file_is_open = 1'b1;
        exp_seq      = exp_seq + 32'd1;
        queue_ack(nxt, 1'b1, 1'b1, dlen, 1'b1);
      end
    end else if (flag_set(F_DATA)) begin
      if (cur_seq != exp_seq) begin
        queue_ack(exp_seq, 1'b0, 1'b0, '0, 1'b1);
      end else if (!file_is_open) begin
        queue_status(EV_NONE);
      end else begin
        exp_seq = exp_seq + 32'd1;
        queue_ack(nxt, 1'b1, 1'b0, dlen, 1'b1);
      end
    end else if (flag_set(F_FIN)) begin
      file_is_open = 1'b0;
      exp_seq      = 32'd0;
      queue_ack(nxt, 1'b0, 1'b0, '0, 1'b1);
    end else if (flag_set(F_CLOSE)) begin
      queue_ack(nxt, 1'b0, 1'b0, '0, 1'b0);
      queue_reply(EV_REPLY, 32'd0, F_FIN, ones_fold({26'd0, F_FIN}), 1'b0, 1'b0, 1'b0, '0, 1'b1);
      close_pending = 1'b1;
    end else begin
      queue_status(EV_NONE);
    end
  endfunction

  function automatic void predict_word(input logic [15:0] w, input logic fend);
    if (cur_idx < FRAME_WORDS) begin
      case (cur_idx)
        W_SEQ_LO: cur_seq[15:0]  = w;
        W_SEQ_HI: cur_seq[31:16] = w;
        W_FLAGS:  cur_flags      = w;
        W_LEN:    cur_len        = w;
        default: ;
      endcase
      if (cur_idx == W_CKSUM) cur_cksum = w;
      else cur_sum = cur_sum + {16'd0, w};
      if (cur_idx >= BODY_START) cur_body = cur_body + {16'd0, w};
      cur_idx++;
    end
    if (fend) begin
      predict_frame();
      clear_frame();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  task automatic send_word(input logic [15:0] w, input logic fend);
    logic rdy;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    word_i      <= w;
    frame_end_i <= fend;
    do begin
      @(negedge clk_i);
      rdy = in_ready_o;
      if (rdy) predict_word(w, fend);
      @(posedge clk_i);
    end while (!rdy);
    words_sent++;
  endtask

  // keep > 0 cuts the frame short after that many words
  task automatic send_frame(input logic [31:0] seq, input logic [31:0] ack,
                            input logic [15:0] flg, input logic [15:0] len, input int nbody,
                            input logic corrupt, input int keep);
    logic [15:0] w[$];
    logic [31:0] s;
    int          n;
    w.push_back(seq[15:0]);
    w.push_back(seq[31:16]);
    w.push_back(ack[15:0]);
    w.push_back(ack[31:16]);
    w.push_back(flg);
    w.push_back(len);
    w.push_back(16'd0);
    repeat (nbody) w.push_back(16'($urandom));
    s = 32'd0;
    foreach (w[i]) if (i != W_CKSUM && i < FRAME_WORDS) s = s + {16'd0, w[i]};
    w[W_CKSUM] = ones_fold(s) ^ (corrupt ? 16'($urandom_range(1, 65535)) : 16'd0);
    n = (keep > 0 && keep < w.size()) ? keep : w.size();
    for (int i = 0; i < n; i++) send_word(w[i], i == n - 1);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_idle(input int sender_pct, input int recv_pct);
    sender_idle_pct = sender_pct;
    recv_stall_pct  = recv_pct;
  endtask

  task automatic test_directed_cases();
    logic [31:0] s;
    logic [15:0] p;
    send_frame(32'd0, 32'd0, {10'd0, F_DATA}, 16'd0, 0, 1'b0, 0);   // data, no file open
    send_frame(32'd0, 32'd0, 16'h0000, 16'd0, 0, 1'b0, 0);          // no flag at all
    send_frame(32'd0, 32'd0, 16'hFFC0, 16'd0, 0, 1'b0, 0);          // unknown flag bits only
    send_frame(32'd3, 32'd0, {10'd0, F_ACK}, 16'd0, 0, 1'b0, 0);    // bare ack
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, {10'd0, F_SYN}, 16'd4, 2, 1'b0, 0);
    send_frame(32'd9, 32'd0, 16'h003F, 16'hFFFF, 1, 1'b0, 0);       // syn wins priority
    send_frame(32'd0, 32'd0, {10'd0, F_FILENAME}, 16'd6, 3, 1'b0, 0);
    send_frame(32'd1, 32'd0, {10'd0, F_DATA}, 16'hFFFF, 2, 1'b0, 0); // length saturates
    send_frame(32'd5, 32'd0, {10'd0, F_DATA}, 16'd2, 1, 1'b0, 0);    // data out of order
    send_frame(32'd7, 32'd0, {10'd0, F_FILENAME}, 16'd2, 1, 1'b0, 0); // name out of order
    send_frame(exp_seq, 32'd0, {10'd0, F_FILENAME}, 16'd4, 2, 1'b0, 0); // replaces open file
    send_frame(exp_seq, 32'd0, {10'd0, F_DATA}, 16'd2, 1, 1'b1, 0);  // bad checksum
    // six-word frame: checksum word never arrives, length word balances the sum to zero
    s = {16'd0, exp_seq[15:0]} + {16'd0, exp_seq[31:16]} + {26'd0, F_DATA};
    p = ~ones_fold(s);
    send_word(exp_seq[15:0], 1'b0);
    send_word(exp_seq[31:16], 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'd0, 1'b0);
    send_word({10'd0, F_DATA}, 1'b0);
    send_word(16'hFFFF - p, 1'b1);
    send_frame(32'h0001_0002, 32'd0, {10'd0, F_DATA}, 16'd0, 0, 1'b0, 3); // cut after three words
    send_frame(32'hFFFF_FFFF, 32'd0, {10'd0, F_FIN}, 16'd0, 0, 1'b0, 0);  // ack wraps to zero
    send_frame(32'd7, 32'd0, {10'd0, F_CLOSE}, 16'd0, 0, 1'b0, 0);
    send_frame(32'd0, 32'd0, {10'd0, F_ACK}, 16'd0, 0, 1'b1, 0);   // bad frame ends the wait
    send_frame(32'd20, 32'd0, {10'd0, F_CLOSE}, 16'd0, 0, 1'b0, 0);
    send_frame(32'd0, 32'd0, {10'd0, F_DATA}, 16'd0, 0, 1'b0, 0);  // not handled after close
  endtask

  task automatic test_random_traffic(input int n_words);
    int          stop;
    int          pick;
    int          nbody;
    int          keep;
    logic [15:0] flg;
    logic [15:0] len;
    logic [31:0] seq;
    logic        bad;
    stop = words_sent + n_words;
    while (words_sent < stop) begin
      pick  = $urandom_range(99);
      seq   = exp_seq;
      nbody = $urandom_range(0, 12);
      len   = ($urandom_range(7) == 0) ? 16'($urandom) : 16'(2 * nbody);
      bad   = ($urandom_range(19) == 0);
      keep  = ($urandom_range(32) == 0) ? $urandom_range(1, 6) : 0;
      if (pick < 8) begin
        flg = 16'($urandom);
        seq = $urandom;
      end else if (pick < 14) begin
        flg = {10'd0, F_SYN};
        seq = $urandom;
      end else if (!file_is_open) begin
        flg = (pick < 20) ? {10'd0, F_DATA} : {10'd0, F_FILENAME};
        if ($urandom_range(9) == 0) seq = seq + $urandom_range(1, 3);
      end else if (pick < 20) begin
        flg = {10'd0, F_FIN};
        seq = $urandom;
      end else if (pick < 24) begin
        flg = {10'd0, F_CLOSE};
        seq = $urandom;
      end else if (pick < 27) begin
        flg = {10'd0, F_ACK};
      end else begin
        flg = ($urandom_range(15) == 0) ? {10'd0, F_FILENAME} : {10'd0, F_DATA};
        if ($urandom_range(9) == 0) seq = ($urandom_range(1) == 0) ? seq - 32'd1 : $urandom;
      end
      // lower-priority and unused bits must not change the handling
      if ($urandom_range(3) == 0) flg = flg | {10'd0, F_ACK};
      if ($urandom_range(5) == 0) flg = flg | (16'($urandom) & 16'hFFC0);
      // an ack right after a close would shut the link for the rest of the run
      if (close_pending) flg = flg & ~{10'd0, F_ACK};
      send_frame(seq, $urandom, flg, len, nbody, bad, keep);
    end
  endtask

  task automatic test_output_stall();
    stall_hold = 150;
    repeat (8) begin
      send_frame(exp_seq, $urandom, file_is_open ? {10'd0, F_DATA} : {10'd0, F_FILENAME},
                 16'($urandom_range(0, 8)), $urandom_range(0, 3), 1'b0, 0);
    end
    wait_drained();
  endtask

  task automatic test_long_frames();
    // words past the frame limit must be ignored
    send_frame($urandom, $urandom, {10'd0, F_SYN}, 16'($urandom),
               FRAME_WORDS - BODY_START + 9, 1'b0, 0);
  endtask

  task automatic test_connection_close();
    if (close_pending) send_frame(32'd0, 32'd0, 16'h0000, 16'd0, 0, 1'b0, 0);
    send_frame($urandom, 32'd0, {10'd0, F_CLOSE}, 16'd0, 0, 1'b0, 0);
    send_frame(32'd0, 32'd0, {10'd0, F_ACK}, 16'd0, 0, 1'b0, 0);
    send_frame($urandom, 32'd0, {10'd0, F_SYN}, 16'd2, 1, 1'b0, 0);
    send_frame(exp_seq, 32'd0, {10'd0, F_DATA}, 16'd2, 1, 1'b1, 0);
    send_frame($urandom, 32'd0, {10'd0, F_CLOSE}, 16'd0, 0, 1'b0, 0);
  endtask

  always @(posedge clk_i) begin
    if (stall_hold > 0) begin
      out_ready_i <= 1'b0;
      stall_hold = stall_hold - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(negedge clk_i) begin
    reply_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected result, event", {30'd0, event_res_o}, 32'd0);
      end else begin
        e = pending_replies.pop_front();
        if (event_res_o !== e.ev) report_mismatch("event_res", {30'd0, event_res_o}, {30'd0, e.ev});
        if (reply_seq_o !== e.seq) report_mismatch("reply_seq", reply_seq_o, e.seq);
        if (reply_ack_o !== e.ack) report_mismatch("reply_ack", reply_ack_o, e.ack);
        if (reply_flags_o !== e.flags)
          report_mismatch("reply_flags", {26'd0, reply_flags_o}, {26'd0, e.flags});
        if (reply_checksum_o !== e.cksum)
          report_mismatch("reply_checksum", {16'd0, reply_checksum_o}, {16'd0, e.cksum});
        if (echo_payload_o !== e.echo)
          report_mismatch("echo_payload", {31'd0, echo_payload_o}, {31'd0, e.echo});
        if (deliver_o !== e.deliver)
          report_mismatch("deliver", {31'd0, deliver_o}, {31'd0, e.deliver});
        if (deliver_is_name_o !== e.is_name)
          report_mismatch("deliver_is_name", {31'd0, deliver_is_name_o}, {31'd0, e.is_name});
        if (deliver_length_o !== e.len)
          report_mismatch("deliver_length", 32'(deliver_length_o), 32'(e.len));
        if (last_o !== e.last) report_mismatch("last", {31'd0, last_o}, {31'd0, e.last});
      end
    end
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    clear_frame();
    exp_seq       = 32'd0;
    file_is_open  = 1'b0;
    close_pending = 1'b0;
    link_closed   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idle(10, 46);
    test_directed_cases();
    test_random_traffic(25);
    set_idle(46, 10);
    test_random_traffic(25);
    test_output_stall();
    set_idle(0, 0);
    test_random_traffic(25);
    test_long_frames();
    test_connection_close();

    wait_drained();
    if (pending_replies.size() != 0)
      report_mismatch("results never arrived", pending_replies.size(), 32'd0);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
